// ----- rtl/knde_pkg.sv -----
// Shared types, constants and segment decode for the keypad number entry display unit.
`timescale 1ns / 1ps

package knde_pkg;

	// Input item: scan tick or key press
	typedef struct packed {
		logic       command;
		logic [3:0] key_code;
	} in_item_t;

	// Result item: display drive and held digits
	typedef struct packed {
		logic [2:0] digit_select;
		logic [7:0] segments;
		logic       asleep;
		logic [3:0] units;
		logic [3:0] tens;
		logic [3:0] hundreds;
	} out_item_t;

	// Configuration registers as seen by the core
	typedef struct packed {
		logic [15:0] entry_timeout;
		logic [15:0] sleep_timeout;
	} cfg_t;

	// Command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_KEY  = 1'b1;

	// Key codes
	localparam logic [3:0] BLANK_DIGIT = 4'd10;
	localparam logic [3:0] KEY_NEXT    = 4'h B;
	localparam logic [3:0] KEY_PREV    = 4'h C;

	// Register map: word index decoded from paddr[2]
	localparam int          PADDR_W           = 3;
	localparam logic        REG_ENTRY_TIMEOUT = 1'b0;
	localparam logic        REG_SLEEP_TIMEOUT = 1'b1;
	localparam logic [15:0] ENTRY_TIMEOUT_RST = 16'd750;
	localparam logic [15:0] SLEEP_TIMEOUT_RST = 16'd12105;

	// Reset values of the held number
	localparam logic [3:0] UNITS_RST    = 4'd1;
	localparam logic [3:0] TENS_RST     = 4'd2;
	localparam logic [3:0] HUNDREDS_RST = 4'd3;

	localparam logic [7:0] SEG_OFF = 8'hFF;

	// Active-high segment pattern for a digit; blank and out-of-range codes are dark
	function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
		logic [7:0] pat;
		case (digit)
			4'd0:    pat = 8'h3F;
			4'd1:    pat = 8'h06;
			4'd2:    pat = 8'h5B;
			4'd3:    pat = 8'h4F;
			4'd4:    pat = 8'h66;
			4'd5:    pat = 8'h6D;
			4'd6:    pat = 8'h7D;
			4'd7:    pat = 8'h07;
			4'd8:    pat = 8'h7F;
			4'd9:    pat = 8'h67;
			default: pat = 8'h00;
		endcase
		return pat;
	endfunction

endpackage

// ----- rtl/knde_cfg.sv -----
// APB-style configuration registers for entry and sleep timeouts.
`timescale 1ns / 1ps

module knde_cfg import knde_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [15:0] entry_timeout_q;
	logic [15:0] sleep_timeout_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_timeout_q <= ENTRY_TIMEOUT_RST;
			sleep_timeout_q <= SLEEP_TIMEOUT_RST;
		end else if (wr_en) begin
			if (paddr[2] == REG_ENTRY_TIMEOUT) begin
				entry_timeout_q <= pwdata[15:0];
			end else begin
				sleep_timeout_q <= pwdata[15:0];
			end
		end
	end

	// Read mux
	always_comb begin
		if (paddr[2] == REG_SLEEP_TIMEOUT) begin
			prdata = {16'd0, sleep_timeout_q};
		end else begin
			prdata = {16'd0, entry_timeout_q};
		end
	end

	assign cfg.entry_timeout = entry_timeout_q;
	assign cfg.sleep_timeout = sleep_timeout_q;

endmodule

// ----- rtl/knde_core.sv -----
// Input register, held number, scan and timer state, and the per-item update logic.
`timescale 1ns / 1ps

module knde_core import knde_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	input  logic      res_ready,
	output logic      res_valid,
	output out_item_t res_item
);

	// Input stage
	logic     valid_s1;
	in_item_t item_s1;
	logic     adv;

	// Block state
	logic [3:0]  units_q, tens_q, hundreds_q;
	logic [1:0]  pos_q;
	logic [15:0] etmr_q, itmr_q;
	logic [1:0]  sidx_q;
	logic [2:0]  sel_q;
	logic [7:0]  seg_q;
	logic        slp_q;

	// Next state
	logic [3:0]  units_n, tens_n, hundreds_n;
	logic [1:0]  pos_n;
	logic [15:0] etmr_n, itmr_n;
	logic [1:0]  sidx_n;
	logic [2:0]  sel_n;
	logic [7:0]  seg_n;
	logic        slp_n;
	logic [3:0]  scan_digit;
	logic [16:0] etmr_inc, itmr_inc;

	assign adv       = valid_s1 && res_ready;
	assign in_stall  = valid_s1 && !res_ready;
	assign res_valid = adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// Update for one item
	always_comb begin
		units_n    = units_q;
		tens_n     = tens_q;
		hundreds_n = hundreds_q;
		pos_n      = pos_q;
		etmr_n     = etmr_q;
		itmr_n     = itmr_q;
		sidx_n     = sidx_q;
		sel_n      = sel_q;
		seg_n      = seg_q;
		slp_n      = slp_q;
		scan_digit = BLANK_DIGIT;
		etmr_inc   = 17'd0;
		itmr_inc   = 17'd0;

		if (item_s1.command == CMD_TICK) begin
			if (!slp_q) begin
				// advance the scan, wrap after the hundreds digit
				if (sidx_q >= 2'd2) begin
					sidx_n = 2'd0;
					sel_n  = 3'b001;
				end else begin
					sidx_n = sidx_q + 2'd1;
					sel_n  = {sel_q[1:0], 1'b0};
				end
				case (sidx_n)
					2'd0:    scan_digit = units_q;
					2'd1:    scan_digit = tens_q;
					2'd2:    scan_digit = hundreds_q;
					default: scan_digit = BLANK_DIGIT;
				endcase
				seg_n = ~seg_pattern(scan_digit);

				// entry timer: a partial entry ends on timeout
				if (etmr_q != 16'd0) begin
					etmr_inc = {1'b0, etmr_q} + 17'd1;
					if (etmr_inc >= {1'b0, cfg.entry_timeout} || etmr_inc[16]) begin
						etmr_n = 16'd0;
						pos_n  = 2'd0;
						itmr_n = 16'd1;
					end else begin
						etmr_n = etmr_inc[15:0];
					end
				end

				// inactivity timer, sees a restart from the entry timeout
				if (itmr_n != 16'd0) begin
					itmr_inc = {1'b0, itmr_n} + 17'd1;
					if (itmr_inc > {1'b0, cfg.sleep_timeout} || itmr_inc[16]) begin
						slp_n  = 1'b1;
						itmr_n = 16'd0;
						sel_n  = 3'b000;
						seg_n  = SEG_OFF;
					end else begin
						itmr_n = itmr_inc[15:0];
					end
				end
			end
		end else begin
			// a key wakes the block first
			if (slp_q) begin
				slp_n  = 1'b0;
				sidx_n = 2'd0;
				sel_n  = 3'b001;
				itmr_n = 16'd1;
			end
			case (item_s1.key_code) inside
				KEY_NEXT: begin
					if (units_q >= 4'd9) begin
						units_n = 4'd0;
						if (tens_q >= 4'd9) begin
							tens_n = 4'd0;
							if (hundreds_q >= 4'd9) begin
								units_n    = 4'd9;
								tens_n     = 4'd9;
								hundreds_n = 4'd9;
							end else begin
								hundreds_n = hundreds_q + 4'd1;
							end
						end else begin
							tens_n = tens_q + 4'd1;
						end
					end else begin
						units_n = units_q + 4'd1;
					end
				end
				KEY_PREV: begin
					if (units_q == 4'd0) begin
						units_n = 4'd9;
						if (tens_q == 4'd0) begin
							tens_n = 4'd9;
							if (hundreds_q == 4'd0) begin
								units_n    = 4'd0;
								tens_n     = 4'd0;
								hundreds_n = 4'd0;
							end else begin
								hundreds_n = hundreds_q - 4'd1;
							end
						end else begin
							tens_n = tens_q - 4'd1;
						end
					end else begin
						units_n = units_q - 4'd1;
					end
				end
				[4'd0:BLANK_DIGIT]: begin
					// left-entry: new digit shifts in at the units place
					case (pos_q)
						2'd0: begin
							units_n    = item_s1.key_code;
							tens_n     = BLANK_DIGIT;
							hundreds_n = BLANK_DIGIT;
							etmr_n     = 16'd1;
							itmr_n     = 16'd1;
							pos_n      = 2'd1;
						end
						2'd1: begin
							tens_n  = units_q;
							units_n = item_s1.key_code;
							etmr_n  = 16'd1;
							itmr_n  = 16'd1;
							pos_n   = 2'd2;
						end
						2'd2: begin
							hundreds_n = tens_q;
							tens_n     = units_q;
							units_n    = item_s1.key_code;
							etmr_n     = 16'd0;
							itmr_n     = 16'd1;
							pos_n      = 2'd0;
						end
						default: begin
							pos_n = 2'd0;
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	// State registers, written when the item moves to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			units_q    <= UNITS_RST;
			tens_q     <= TENS_RST;
			hundreds_q <= HUNDREDS_RST;
			pos_q      <= 2'd0;
			etmr_q     <= 16'd0;
			itmr_q     <= 16'd1;
			sidx_q     <= 2'd0;
			sel_q      <= 3'b001;
			seg_q      <= SEG_OFF;
			slp_q      <= 1'b0;
		end else if (adv) begin
			units_q    <= units_n;
			tens_q     <= tens_n;
			hundreds_q <= hundreds_n;
			pos_q      <= pos_n;
			etmr_q     <= etmr_n;
			itmr_q     <= itmr_n;
			sidx_q     <= sidx_n;
			sel_q      <= sel_n;
			seg_q      <= seg_n;
			slp_q      <= slp_n;
		end
	end

	// Result is the state after the item
	assign res_item.digit_select = sel_n;
	assign res_item.segments     = seg_n;
	assign res_item.asleep       = slp_n;
	assign res_item.units        = units_n;
	assign res_item.tens         = tens_n;
	assign res_item.hundreds     = hundreds_n;

endmodule

// ----- rtl/knde_skid.sv -----
// Result register with a skid stage so the core can pass one more result while a result waits.
`timescale 1ns / 1ps

module knde_skid import knde_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	input  out_item_t push_item,
	output logic      push_ready,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	logic      out_valid_q, skid_valid_q;
	out_item_t out_q, skid_q;
	logic      drain;

	assign push_ready = !skid_valid_q;
	assign drain      = !out_valid_q || !out_stall;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			out_valid_q  <= skid_valid_q || push_valid;
			skid_valid_q <= 1'b0;
		end else if (push_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload, oldest item to the output first
	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push_valid) begin
				out_q <= push_item;
			end
		end else if (push_valid) begin
			skid_q <= push_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ----- rtl/keypad_number_entry_display_unit.sv -----
// Path: an item passes the input register and update logic into the result register,
// and waits in the skid stage while the output stalls. Throughput: one item per cycle
// while out_stall is low; the input register, one pass of update logic and a result
// register with a skid stage set this. in_stall follows out_stall via the skid stage.
// Reset (arst_n low): number 321, scan on the units digit, segments dark, awake,
// timeouts 750 and 12105 ticks; no items held.
`timescale 1ns / 1ps

module keypad_number_entry_display_unit import knde_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_item
);

	cfg_t      cfg;
	logic      res_valid, res_ready;
	out_item_t res_item;

	// Configuration registers
	knde_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Update logic and state
	knde_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	// Result register and skid stage
	knde_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (res_valid),
		.push_item  (res_item),
		.push_ready (res_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule

// ----- rtl/knde_checker.sv -----
// Port-level checks for the keypad number entry display unit, bound to the top level.
`timescale 1ns / 1ps

module knde_checker import knde_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               pready,
	input logic               in_valid,
	input logic               in_stall,
	input in_item_t           in_item,
	input logic               out_valid,
	input logic               out_stall,
	input out_item_t          out_item
);

	// Asleep means a dark display with no digit selected
	a_sleep_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.asleep |-> out_item.digit_select == 3'b000 &&
		out_item.segments == SEG_OFF)
		else $error("asleep result drives the display");

	// Awake, exactly one digit is selected
	a_awake_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.asleep |-> $onehot(out_item.digit_select))
		else $error("awake result without a one-hot digit select");

	// Held digits stay within 0-9 or blank
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.units <= BLANK_DIGIT && out_item.tens <= BLANK_DIGIT &&
		out_item.hundreds <= BLANK_DIGIT)
		else $error("held digit out of range");

	// A stalled result stays presented unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result item changed or dropped");

endmodule

bind keypad_number_entry_display_unit knde_checker u_knde_checker (.*);

// ----- verif/keypad_number_entry_display_unit_test.sv -----
// Testbench for the keypad number entry display unit: it predicts and checks every result item.
`timescale 1ns / 1ps

module keypad_number_entry_display_unit_test;
	import knde_pkg::*;

	localparam int          HALF_PERIOD    = 5;
	localparam int          QUIET_LIMIT    = 2000;
	localparam int          PHASE_ITEMS    = 150;
	localparam int          SETTLE_CYCLES  = 4;
	localparam logic [3:0]  KEY_IGNORED_LO = 4'd13;
	localparam logic [3:0]  KEY_IGNORED_HI = 4'd15;

	// Block ports, inputs driven from time zero
	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [31:0]        pwdata  = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	in_item_t           in_item   = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_item_t          out_item;

	// Idling control, percent of cycles
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;

	int unsigned mismatches   = 0;
	int unsigned quiet_cycles = 0;

	// Expected display states, oldest first
	out_item_t display_q[$];
	out_item_t want;

	// Predicted state of the unit
	int          num_digit[3];
	int unsigned entry_pos;
	int unsigned entry_tmr;
	int unsigned idle_tmr;
	int unsigned scan_idx;
	int unsigned sel_r;
	int unsigned seg_r;
	bit          dozing;
	int unsigned cfg_entry_to;
	int unsigned cfg_sleep_to;

	keypad_number_entry_display_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	always #HALF_PERIOD clk = ~clk;

	// ---------------------------------------------------------------
	// Display predictor
	// ---------------------------------------------------------------

	function void reset_display_model();
		num_digit[0] = 1;
		num_digit[1] = 2;
		num_digit[2] = 3;
		entry_pos    = 0;
		entry_tmr    = 0;
		idle_tmr     = 1;
		scan_idx     = 0;
		sel_r        = 1;
		seg_r        = 8'hFF;
		dozing       = 1'b0;
		cfg_entry_to = 750;
		cfg_sleep_to = 12105;
	endfunction

	// Active-low pattern; blank is dark
	function automatic logic [7:0] dark_low_segments(int d);
		logic [7:0] lit;
		case (d)
			0:       lit = 8'h3F;
			1:       lit = 8'h06;
			2:       lit = 8'h5B;
			3:       lit = 8'h4F;
			4:       lit = 8'h66;
			5:       lit = 8'h6D;
			6:       lit = 8'h7D;
			7:       lit = 8'h07;
			8:       lit = 8'h7F;
			9:       lit = 8'h67;
			default: lit = 8'h00;
		endcase
		return ~lit;
	endfunction

	// Decimal count up, clamps at 999; blank rolls over with a carry
	function void count_number_up();
		num_digit[0] += 1;
		if (num_digit[0] > 9) begin
			num_digit[0] = 0;
			num_digit[1] += 1;
			if (num_digit[1] > 9) begin
				num_digit[1] = 0;
				num_digit[2] += 1;
				if (num_digit[2] > 9) begin
					num_digit[0] = 9;
					num_digit[1] = 9;
					num_digit[2] = 9;
				end
			end
		end
	endfunction

	// Decimal count down, clamps at 000; blank counts as ten
	function void count_number_down();
		num_digit[0] -= 1;
		if (num_digit[0] < 0) begin
			num_digit[0] = 9;
			num_digit[1] -= 1;
			if (num_digit[1] < 0) begin
				num_digit[1] = 9;
				num_digit[2] -= 1;
				if (num_digit[2] < 0) begin
					num_digit[0] = 0;
					num_digit[1] = 0;
					num_digit[2] = 0;
				end
			end
		end
	endfunction

	// Left-entry shift of a digit key
	function void shift_in_digit(int k);
		case (entry_pos)
			0: begin
				num_digit[0] = k;
				num_digit[1] = 10;
				num_digit[2] = 10;
				entry_tmr    = 1;
				idle_tmr     = 1;
				entry_pos    = 1;
			end
			1: begin
				num_digit[1] = num_digit[0];
				num_digit[0] = k;
				entry_tmr    = 1;
				idle_tmr     = 1;
				entry_pos    = 2;
			end
			2: begin
				num_digit[2] = num_digit[1];
				num_digit[1] = num_digit[0];
				num_digit[0] = k;
				entry_tmr    = 0;
				idle_tmr     = 1;
				entry_pos    = 0;
			end
			default: begin
				entry_pos = 0;
			end
		endcase
	endfunction

	// Scan step plus both timers
	function void advance_scan();
		int unsigned t;
		scan_idx += 1;
		sel_r = (sel_r << 1) & 7;
		if (scan_idx > 2) begin
			scan_idx = 0;
			sel_r    = 1;
		end
		seg_r = dark_low_segments(num_digit[scan_idx]);
		if (entry_tmr >= 1) begin
			t = entry_tmr + 1;
			if (t >= cfg_entry_to || t > 32'hFFFF) begin
				entry_tmr = 0;
				entry_pos = 0;
				idle_tmr  = 1;
			end else begin
				entry_tmr = t;
			end
		end
		if (idle_tmr >= 1) begin
			t = idle_tmr + 1;
			if (t > cfg_sleep_to || t > 32'hFFFF) begin
				dozing   = 1'b1;
				idle_tmr = 0;
				sel_r    = 0;
				seg_r    = 8'hFF;
			end else begin
				idle_tmr = t;
			end
		end
	endfunction

	function out_item_t step_display(in_item_t it);
		out_item_t r;
		if (it.command == CMD_TICK) begin
			if (!dozing)
				advance_scan();
		end else begin
			// a key wakes the unit first, then is handled
			if (dozing) begin
				dozing   = 1'b0;
				scan_idx = 0;
				sel_r    = 1;
				idle_tmr = 1;
			end
			if (it.key_code == KEY_NEXT)
				count_number_up();
			else if (it.key_code == KEY_PREV)
				count_number_down();
			else if (it.key_code <= BLANK_DIGIT)
				shift_in_digit(int'(it.key_code));
		end
		r.digit_select = 3'(sel_r);
		r.segments     = 8'(seg_r);
		r.asleep       = dozing;
		r.units        = 4'(num_digit[0]);
		r.tens         = 4'(num_digit[1]);
		r.hundreds     = 4'(num_digit[2]);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Result checking, receiver stall and watchdog
	// ---------------------------------------------------------------

	function void check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (display_q.size() == 0) begin
				mismatches++;
				$display("%0t: result item with none expected, got %h", $time, out_item);
			end else begin
				want = display_q.pop_front();
				check_field("digit_select", want.digit_select, out_item.digit_select);
				check_field("segments", want.segments, out_item.segments);
				check_field("asleep", want.asleep, out_item.asleep);
				check_field("units", want.units, out_item.units);
				check_field("tens", want.tens, out_item.tens);
				check_field("hundreds", want.hundreds, out_item.hundreds);
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	// Ends the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Shared drivers
	// ---------------------------------------------------------------

	// Sends one item, predicts it on acceptance
	task automatic send_item(input logic cmd, input logic [3:0] key);
		in_item_t it;
		it.command  = cmd;
		it.key_code = key;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		display_q.push_back(step_display(it));
	endtask

	task automatic send_tick();
		send_item(CMD_TICK, 4'($urandom_range(15)));
	endtask

	task automatic send_key(input logic [3:0] key);
		send_item(CMD_KEY, key);
	endtask

	// Waits until every expected item is back and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		while (display_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [15:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'h0000, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_expect(input logic idx, input logic [15:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[15:0] !== v) begin
			mismatches++;
			$display("%0t: register %0d expected %0d, got %0d", $time, idx, v, prdata[15:0]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Reprograms both timeouts once the unit is idle
	task automatic set_timeouts(input logic [15:0] entry_to, input logic [15:0] sleep_to);
		settle();
		reg_write(REG_ENTRY_TIMEOUT, entry_to);
		reg_write(REG_SLEEP_TIMEOUT, sleep_to);
		cfg_entry_to = entry_to;
		cfg_sleep_to = sleep_to;
		reg_expect(REG_ENTRY_TIMEOUT, entry_to);
		reg_expect(REG_SLEEP_TIMEOUT, sleep_to);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Reset values, ignored keys and scan wrap
	task automatic test_reset_state();
		reg_expect(REG_ENTRY_TIMEOUT, ENTRY_TIMEOUT_RST);
		reg_expect(REG_SLEEP_TIMEOUT, SLEEP_TIMEOUT_RST);
		send_key(KEY_IGNORED_HI);
		send_key(KEY_IGNORED_LO);
		send_item(CMD_TICK, 4'd0);
		send_item(CMD_TICK, 4'd15);
		send_tick();
	endtask

	// Full entries, clamps, blank digits counted both ways
	task automatic test_digit_entry();
		send_key(4'd9);
		send_key(4'd9);
		send_key(4'd8);
		send_key(KEY_NEXT);
		send_key(KEY_NEXT);
		send_key(4'd0);
		send_key(4'd0);
		send_key(4'd0);
		send_key(KEY_PREV);
		send_key(BLANK_DIGIT);
		send_key(KEY_NEXT);
		send_key(BLANK_DIGIT);
		send_key(KEY_PREV);
		send_key(4'd14);
		send_tick();
	endtask

	// Entry timeout, sleep, tick while asleep, wake by a key
	task automatic test_timeouts();
		set_timeouts(16'd2, 16'd3);
		send_key(4'd5);
		send_tick();
		send_key(4'd6);
		send_tick();
		send_tick();
		send_tick();
		send_tick();
		send_key(KEY_PREV);
		send_tick();
	endtask

	// Random items, digit bursts mixed with ticks and counting keys
	task automatic send_random_item();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45)
			send_tick();
		else if (r < 75)
			send_key(4'($urandom_range(10)));
		else if (r < 85)
			send_key(KEY_NEXT);
		else if (r < 95)
			send_key(KEY_PREV);
		else
			send_key(4'($urandom_range(KEY_IGNORED_HI, KEY_IGNORED_LO)));
	endtask

	task automatic test_random_traffic();
		int unsigned n;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_timeouts(16'd2, 16'd1);
				1: set_timeouts(16'($urandom_range(12, 2)), 16'($urandom_range(40, 1)));
				2: set_timeouts(16'($urandom_range(12, 2)), 16'($urandom_range(40, 2)));
				default: set_timeouts(16'd65535, 16'd65534);
			endcase
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 61; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 61; end
				default: begin idle_pct = 6; stall_pct = 6; end
			endcase
			n = 0;
			while (n < PHASE_ITEMS) begin
				if ($urandom_range(99) < 15) begin
					// three digit keys in a row
					send_key(4'($urandom_range(9)));
					send_key(4'($urandom_range(10)));
					send_key(4'($urandom_range(10)));
					n += 3;
				end else begin
					send_random_item();
					n++;
				end
			end
		end
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	// Widest entry timeout and timeouts below the usual range
	task automatic test_timeout_extremes();
		set_timeouts(16'd65535, 16'd24);
		send_key(4'd4);
		while (!dozing)
			send_item(CMD_TICK, 4'($urandom_range(15)));
		send_tick();
		send_key(KEY_NEXT);
		set_timeouts(16'd0, 16'd3);
		send_key(4'd2);
		send_tick();
		send_key(4'd3);
		set_timeouts(16'd1, 16'd0);
		send_key(4'd8);
		send_tick();
		send_key(4'd1);
		send_tick();
	endtask

	initial begin
		reset_display_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_digit_entry();
		test_timeouts();
		test_random_traffic();
		test_timeout_extremes();
		settle();

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
